### src/sccrt_pkg.sv
// shared types, constants and helper functions for the swept circle collision core
`default_nettype none

package sccrt_pkg;

    localparam int STEPS = 6;
    localparam int FB = STEPS + 1;
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);
    localparam logic [15:0] NORM_ONE = 16'd16384;

    typedef logic signed [23:0] coord_t;
    typedef logic [22:0] len_t;
    typedef logic signed [24:0] pos_t;
    typedef logic signed [25:0] vec_t;
    typedef logic [51:0] sq_t;
    typedef logic [45:0] r2_t;
    typedef logic [FB-1:0] frac_t;

    typedef struct packed {
        coord_t ball_x;
        coord_t ball_y;
        len_t radius;
        coord_t move_x;
        coord_t move_y;
        coord_t box_left;
        coord_t box_top;
        len_t box_width;
        len_t box_height;
    } in_item_t;

    typedef struct packed {
        coord_t bx;
        coord_t by;
        coord_t mx;
        coord_t my;
        coord_t l;
        coord_t t;
        pos_t r;
        pos_t b;
        r2_t r2;
        frac_t scal;
        frac_t best;
        logic found;
        vec_t cvx;
        vec_t cvy;
        logic end_free;
        logic start_free;
        vec_t svx;
        vec_t svy;
    } ctx_t;

    typedef struct packed {
        logic hit;
        logic [6:0] hit_time;
        vec_t vx;
        vec_t vy;
    } q_item_t;

    typedef struct packed {
        logic hit;
        logic [6:0] hit_time;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
    } res_t;

    // offset from the nearest box point to p along one axis
    function automatic vec_t near_diff(pos_t p, pos_t lo, pos_t hi);
        pos_t c;
        c = p;
        if (p < lo) begin
            c = lo;
        end else if (p > hi) begin
            c = hi;
        end
        return vec_t'(p) - vec_t'(c);
    endfunction

    function automatic sq_t sq_mag(vec_t d);
        logic [25:0] m;
        m = d[25] ? $unsigned(-d) : $unsigned(d);
        return m * m;
    endfunction

    // centre plus floor(move * fraction)
    function automatic pos_t step_pos(coord_t b, coord_t m, frac_t s);
        logic signed [24+FB:0] p;
        p = m * $signed({1'b0, s});
        return pos_t'(b) + $signed(p[FB+24:FB]);
    endfunction

endpackage

`default_nettype wire

### src/sccrt_front.sv
// front pipeline: end, start and bisection distance tests, classification of each item
`default_nettype none

module sccrt_front import sccrt_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_item,
    output logic          q_push,
    output q_item_t       q_item,
    input  wire logic     q_full
);

    localparam int NCTX = 4 * STEPS + 1;
    localparam int KF = 4 * STEPS + 1;

    logic [KF:0] v_reg;
    ctx_t ctx_reg [0:NCTX-1];
    pos_t px_reg [0:STEPS-1];
    pos_t py_reg [0:STEPS-1];
    vec_t dxa_reg [0:STEPS-1];
    vec_t dya_reg [0:STEPS-1];
    vec_t dxb_reg [0:STEPS-1];
    vec_t dyb_reg [0:STEPS-1];
    sq_t sqx_reg [0:STEPS-1];
    sq_t sqy_reg [0:STEPS-1];
    ctx_t c_next [0:STEPS-1];

    pos_t epx_reg, epy_reg;
    vec_t edx_reg, edy_reg, sdx_reg, sdy_reg, sdxb_reg, sdyb_reg;
    sq_t esx_reg, esy_reg, ssx_reg, ssy_reg;

    q_item_t q_reg;
    q_item_t q_next;
    ctx_t c_in;
    logic en;
    logic e_free;
    logic s_free;

    assign en = !v_reg[KF] || !q_full;
    assign in_ready = en;
    assign q_push = v_reg[KF] && !q_full;
    assign q_item = q_reg;

    always_comb begin
        c_in = '0;
        c_in.bx = in_item.ball_x;
        c_in.by = in_item.ball_y;
        c_in.mx = in_item.move_x;
        c_in.my = in_item.move_y;
        c_in.l = in_item.box_left;
        c_in.t = in_item.box_top;
        c_in.r = pos_t'(in_item.box_left) + $signed({2'b00, in_item.box_width});
        c_in.b = pos_t'(in_item.box_top) + $signed({2'b00, in_item.box_height});
        c_in.r2 = in_item.radius * in_item.radius;
        c_in.scal = frac_t'(1) << (FB - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[KF-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg[0] <= c_in;
        end
    end

    // end and start positions, tested alongside the first bisection step
    always_ff @(posedge aclk) begin
        if (en) begin
            epx_reg <= pos_t'(ctx_reg[0].bx) + pos_t'(ctx_reg[0].mx);
            epy_reg <= pos_t'(ctx_reg[0].by) + pos_t'(ctx_reg[0].my);
            edx_reg <= near_diff(epx_reg, pos_t'(ctx_reg[1].l), ctx_reg[1].r);
            edy_reg <= near_diff(epy_reg, pos_t'(ctx_reg[1].t), ctx_reg[1].b);
            sdx_reg <= near_diff(pos_t'(ctx_reg[1].bx), pos_t'(ctx_reg[1].l), ctx_reg[1].r);
            sdy_reg <= near_diff(pos_t'(ctx_reg[1].by), pos_t'(ctx_reg[1].t), ctx_reg[1].b);
            esx_reg <= sq_mag(edx_reg);
            esy_reg <= sq_mag(edy_reg);
            ssx_reg <= sq_mag(sdx_reg);
            ssy_reg <= sq_mag(sdy_reg);
            sdxb_reg <= sdx_reg;
            sdyb_reg <= sdy_reg;
        end
    end

    assign e_free = ({1'b0, esx_reg} + {1'b0, esy_reg}) > 53'(ctx_reg[3].r2);
    assign s_free = ({1'b0, ssx_reg} + {1'b0, ssy_reg}) > 53'(ctx_reg[3].r2);

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam int KP = 1 + 4 * g;
        localparam frac_t INC = frac_t'(1) << (FB - 2 - g);
        logic free;

        always_ff @(posedge aclk) begin
            if (en) begin
                ctx_reg[KP] <= ctx_reg[KP-1];
                px_reg[g] <= step_pos(ctx_reg[KP-1].bx, ctx_reg[KP-1].mx, ctx_reg[KP-1].scal);
                py_reg[g] <= step_pos(ctx_reg[KP-1].by, ctx_reg[KP-1].my, ctx_reg[KP-1].scal);
                ctx_reg[KP+1] <= ctx_reg[KP];
                dxa_reg[g] <= near_diff(px_reg[g], pos_t'(ctx_reg[KP].l), ctx_reg[KP].r);
                dya_reg[g] <= near_diff(py_reg[g], pos_t'(ctx_reg[KP].t), ctx_reg[KP].b);
                ctx_reg[KP+2] <= ctx_reg[KP+1];
                sqx_reg[g] <= sq_mag(dxa_reg[g]);
                sqy_reg[g] <= sq_mag(dya_reg[g]);
                dxb_reg[g] <= dxa_reg[g];
                dyb_reg[g] <= dya_reg[g];
                ctx_reg[KP+3] <= c_next[g];
            end
        end

        always_comb begin
            free = ({1'b0, sqx_reg[g]} + {1'b0, sqy_reg[g]}) > 53'(ctx_reg[KP+2].r2);
            c_next[g] = ctx_reg[KP+2];
            if (free) begin
                c_next[g].best = ctx_reg[KP+2].scal;
                c_next[g].scal = ctx_reg[KP+2].scal + INC;
                c_next[g].cvx = dxb_reg[g];
                c_next[g].cvy = dyb_reg[g];
                c_next[g].found = 1'b1;
            end else begin
                c_next[g].scal = ctx_reg[KP+2].scal - INC;
            end
            if (g == 0) begin
                c_next[g].end_free = e_free;
                c_next[g].start_free = s_free;
                c_next[g].svx = sdxb_reg;
                c_next[g].svy = sdyb_reg;
            end
        end
    end

    always_comb begin
        logic [FB+6:0] tw;
        tw = {ctx_reg[NCTX-1].best, 7'b0} >> FB;
        q_next = '0;
        if (!ctx_reg[NCTX-1].end_free) begin
            if (ctx_reg[NCTX-1].found) begin
                q_next.hit = 1'b1;
                q_next.hit_time = tw[6:0];
                q_next.vx = ctx_reg[NCTX-1].cvx;
                q_next.vy = ctx_reg[NCTX-1].cvy;
            end else if (ctx_reg[NCTX-1].start_free) begin
                q_next.hit = 1'b1;
                q_next.vx = ctx_reg[NCTX-1].svx;
                q_next.vy = ctx_reg[NCTX-1].svy;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

endmodule

`default_nettype wire

### src/sccrt_queue.sv
// short queue between the classification front and the normalization back
`default_nettype none

module sccrt_queue import sccrt_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire q_item_t din,
    output logic         full,
    input  wire logic    pop,
    output q_item_t      dout,
    output logic         empty
);

    q_item_t mem_reg [0:QDEPTH-1];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0] cnt_reg;

    assign full = cnt_reg == (QAW+1)'(QDEPTH);
    assign empty = cnt_reg == '0;
    assign dout = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= din;
        end
    end

endmodule

`default_nettype wire

### src/sccrt_norm.sv
// back pipeline: vector scaling, pipelined square root and division into the unit normal
`default_nettype none

module sccrt_norm import sccrt_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire q_item_t q_item,
    input  wire logic    q_empty,
    output logic         q_pop,
    output logic         out_valid,
    input  wire logic    out_ready,
    output res_t         out_res
);

    typedef struct packed {
        logic hit;
        logic [6:0] hit_time;
        logic sgx;
        logic sgy;
        logic [25:0] ax;
        logic [25:0] ay;
    } abs_t;

    typedef struct packed {
        logic hit;
        logic [6:0] hit_time;
        logic sgx;
        logic sgy;
        logic [16:0] ax;
        logic [16:0] ay;
    } meta_t;

    typedef struct packed {
        meta_t m;
        logic [35:0] w;
        logic [35:0] rem;
        logic [31:0] root;
    } sqs_t;

    typedef struct packed {
        logic hit;
        logic [6:0] hit_time;
        logic sgx;
        logic sgy;
        logic [31:0] d;
        logic [47:0] rx;
        logic [47:0] ry;
        logic [15:0] qx;
        logic [15:0] qy;
    } dvs_t;

    logic [3:0] va_reg;
    logic [32:0] vs_reg;
    logic [16:0] vd_reg;
    logic out_valid_reg;

    q_item_t s0_reg;
    abs_t s1_reg;
    abs_t s1_next;
    meta_t s2_reg;
    meta_t s2_next;
    meta_t s3_reg;
    logic [33:0] sqx3_reg, sqy3_reg;
    sqs_t sq_reg [0:32];
    sqs_t sq_nx [0:31];
    sqs_t sq_in;
    logic [35:0] rs [0:31];
    logic [35:0] tr [0:31];
    dvs_t dv_reg [0:16];
    dvs_t dv_nx [0:15];
    dvs_t dv_in;
    logic [47:0] ds [0:15];
    res_t res_reg;
    res_t res_next;
    logic en;

    assign en = !out_valid_reg || out_ready;
    assign q_pop = en && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= '0;
            vs_reg <= '0;
            vd_reg <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            va_reg <= {va_reg[2:0], !q_empty};
            vs_reg <= {vs_reg[31:0], va_reg[3]};
            vd_reg <= {vd_reg[15:0], vs_reg[32]};
            out_valid_reg <= vd_reg[16];
        end
    end

    always_comb begin
        s1_next.hit = s0_reg.hit;
        s1_next.hit_time = s0_reg.hit_time;
        s1_next.sgx = s0_reg.vx[25];
        s1_next.sgy = s0_reg.vy[25];
        s1_next.ax = s0_reg.vx[25] ? $unsigned(-s0_reg.vx) : $unsigned(s0_reg.vx);
        s1_next.ay = s0_reg.vy[25] ? $unsigned(-s0_reg.vy) : $unsigned(s0_reg.vy);
    end

    // drop low bits until both magnitudes fit in 17 bits
    always_comb begin
        logic [25:0] mo;
        logic [4:0] nb;
        logic [3:0] sh;
        logic [25:0] tx;
        logic [25:0] ty;
        mo = s1_reg.ax | s1_reg.ay;
        nb = '0;
        for (int i = 0; i < 26; i++) begin
            if (mo[i]) begin
                nb = 5'(i + 1);
            end
        end
        sh = (nb > 5'd17) ? 4'(nb - 5'd17) : 4'd0;
        tx = s1_reg.ax >> sh;
        ty = s1_reg.ay >> sh;
        s2_next.hit = s1_reg.hit;
        s2_next.hit_time = s1_reg.hit_time;
        s2_next.sgx = s1_reg.sgx;
        s2_next.sgy = s1_reg.sgy;
        s2_next.ax = tx[16:0];
        s2_next.ay = ty[16:0];
    end

    always_comb begin
        sq_in.m = s3_reg;
        sq_in.w = {1'b0, {1'b0, sqx3_reg} + {1'b0, sqy3_reg}};
        sq_in.rem = '0;
        sq_in.root = '0;
    end

    // one root bit per stage
    always_comb begin
        for (int j = 0; j < 32; j++) begin
            sq_nx[j] = sq_reg[j];
            rs[j] = {sq_reg[j].rem[33:0], sq_reg[j].w[35:34]};
            tr[j] = {2'b00, sq_reg[j].root, 2'b01};
            sq_nx[j].w = {sq_reg[j].w[33:0], 2'b00};
            if (rs[j] >= tr[j]) begin
                sq_nx[j].rem = rs[j] - tr[j];
                sq_nx[j].root = {sq_reg[j].root[30:0], 1'b1};
            end else begin
                sq_nx[j].rem = rs[j];
                sq_nx[j].root = {sq_reg[j].root[30:0], 1'b0};
            end
        end
    end

    always_comb begin
        dv_in.hit = sq_reg[32].m.hit;
        dv_in.hit_time = sq_reg[32].m.hit_time;
        dv_in.sgx = sq_reg[32].m.sgx;
        dv_in.sgy = sq_reg[32].m.sgy;
        dv_in.d = sq_reg[32].root;
        dv_in.rx = 48'({sq_reg[32].m.ax, 28'b0}) + 48'(sq_reg[32].root >> 1);
        dv_in.ry = 48'({sq_reg[32].m.ay, 28'b0}) + 48'(sq_reg[32].root >> 1);
        dv_in.qx = '0;
        dv_in.qy = '0;
    end

    // one quotient bit per stage, both components share the divisor
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            dv_nx[k] = dv_reg[k];
            ds[k] = {16'b0, dv_reg[k].d} << (15 - k);
            if (dv_reg[k].rx >= ds[k]) begin
                dv_nx[k].rx = dv_reg[k].rx - ds[k];
                dv_nx[k].qx[15-k] = 1'b1;
            end
            if (dv_reg[k].ry >= ds[k]) begin
                dv_nx[k].ry = dv_reg[k].ry - ds[k];
                dv_nx[k].qy[15-k] = 1'b1;
            end
        end
    end

    always_comb begin
        logic [15:0] cx;
        logic [15:0] cy;
        cx = (dv_reg[16].qx > NORM_ONE) ? NORM_ONE : dv_reg[16].qx;
        cy = (dv_reg[16].qy > NORM_ONE) ? NORM_ONE : dv_reg[16].qy;
        if (dv_reg[16].d == '0) begin
            cx = '0;
            cy = '0;
        end
        res_next.hit = dv_reg[16].hit;
        res_next.hit_time = dv_reg[16].hit_time;
        res_next.normal_x = dv_reg[16].sgx ? $signed(-cx) : $signed(cx);
        res_next.normal_y = dv_reg[16].sgy ? $signed(-cy) : $signed(cy);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_reg <= q_item;
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s2_reg;
            sqx3_reg <= s2_reg.ax * s2_reg.ax;
            sqy3_reg <= s2_reg.ay * s2_reg.ay;
            sq_reg[0] <= sq_in;
            for (int j = 0; j < 32; j++) begin
                sq_reg[j+1] <= sq_nx[j];
            end
            dv_reg[0] <= dv_in;
            for (int k = 0; k < 16; k++) begin
                dv_reg[k+1] <= dv_nx[k];
            end
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

### src/swept_circle_rect_collision_time_core.sv
// throughput: one beat per cycle while the output is not stalled; the front bisection and the
// 32-stage root and 16-stage divide pipelines each take a new item every cycle
// a four-entry queue decouples the front from the back; while results wait, input beats keep
// flowing until the queue and the empty front stages fill
// reset: synchronous active-low aresetn clears all valid flags and queue pointers
`default_nettype none

module swept_circle_rect_collision_time_core import sccrt_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // ball_x, ball_y, radius, move_x, move_y, box_left, box_top, box_width, box_height, pad
    input  wire logic [215:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // hit, hit_time, normal_x, normal_y
    output logic [39:0]       m_axis_tdata
);

    in_item_t in_item;
    q_item_t f_item;
    q_item_t b_item;
    res_t res;
    logic q_push, q_full, q_pop, q_empty;

    assign in_item.ball_x = s_axis_tdata[23:0];
    assign in_item.ball_y = s_axis_tdata[47:24];
    assign in_item.radius = s_axis_tdata[70:48];
    assign in_item.move_x = s_axis_tdata[94:71];
    assign in_item.move_y = s_axis_tdata[118:95];
    assign in_item.box_left = s_axis_tdata[142:119];
    assign in_item.box_top = s_axis_tdata[166:143];
    assign in_item.box_width = s_axis_tdata[189:167];
    assign in_item.box_height = s_axis_tdata[212:190];

    sccrt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_push   (q_push),
        .q_item   (f_item),
        .q_full   (q_full)
    );

    sccrt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (f_item),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (b_item),
        .empty   (q_empty)
    );

    sccrt_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_item    (b_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {res.normal_y, res.normal_x, res.hit_time, res.hit};

endmodule

`default_nettype wire
